// File: rtl/lirs_pkg.sv
// Package for the linear interpolation resampler.
// Holds the configuration register index codes; no dependencies.
package lirs_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BYPASS    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_STEP = 1'b1;

endpackage

// File: rtl/linear_interp_resampler.sv
// Output: an accepted beat is held one result deep, so a result appears on m_ once the next
// result is produced or the item finishes.
// Each interpolated result takes a multiply step on the shared multiplier and then a round step;
// a new source sample is accepted only in idle, once the previous item has been flushed.
// Reset (aresetn, synchronous, active low) clears state and valids, bypass off, step of one.
module linear_interp_resampler
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Source samples
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_in_sample,
    input  logic                            s_in_last,
    // Resampled output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_BITS-1:0]   m_out_sample,
    output logic                            m_out_last,
    // Configuration writes
    input  logic                            cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [PHASE_FRAC_BITS+4:0]      cfg_wdata
);

    localparam int PW       = PHASE_FRAC_BITS + 5;           // phase and step width
    localparam int MW       = SAMPLE_BITS + PHASE_FRAC_BITS + 2; // product width
    localparam logic [PW-1:0] ONE      = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [PW-1:0] STEP_MIN = ONE >> 4;
    localparam logic [PW-1:0] STEP_MAX = ONE << 4;
    localparam logic [PW-1:0] PHASE_BOUND = ONE + STEP_MAX;
    localparam logic signed [MW-1:0] HALF = MW'(1) << (PHASE_FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INTERP,
        S_ROUND,
        S_TAIL,
        S_FLUSH
    } state_t;

    state_t                         state_reg, state_next;
    logic                           bypass_reg, bypass_next;
    logic [PW-1:0]                  rate_step_reg, rate_step_next;
    logic [PW-1:0]                  step_reg, step_next;
    logic [PW-1:0]                  phase_reg, phase_next;
    logic signed [SAMPLE_BITS-1:0]  held_reg, held_next;
    logic                           have_held_reg, have_held_next;
    logic signed [SAMPLE_BITS-1:0]  cur_reg, cur_next;
    logic                           last_reg, last_next;
    logic                           pass_reg, pass_next;
    logic signed [MW-1:0]           prod_reg, prod_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic signed [SAMPLE_BITS-1:0]  pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0]  out_sample_reg, out_sample_next;
    logic                           out_last_reg, out_last_next;

    logic                           out_free;
    logic                           can_produce;
    logic                           produce;
    logic signed [SAMPLE_BITS-1:0]  produce_value;
    logic [PW-1:0]                  step_sat;
    logic signed [SAMPLE_BITS:0]    diff;
    logic signed [PHASE_FRAC_BITS:0] frac;
    logic signed [MW-1:0]           rounded;
    logic signed [SAMPLE_BITS+1:0]  delta;
    logic signed [SAMPLE_BITS+1:0]  interp_wide;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_sample_reg;
    assign m_out_last   = out_last_reg;

    // The output register frees up when empty or when its beat is taken.
    assign out_free    = !out_valid_reg || m_ready;
    assign can_produce = !pend_valid_reg || out_free;

    // Step saturated to the supported range.
    always_comb begin
        if (rate_step_reg < STEP_MIN) begin
            step_sat = STEP_MIN;
        end else if (rate_step_reg > STEP_MAX) begin
            step_sat = STEP_MAX;
        end else begin
            step_sat = rate_step_reg;
        end
    end

    // Shared multiplier operands and the rounding of its registered product.
    assign diff        = (SAMPLE_BITS+1)'(cur_reg) - (SAMPLE_BITS+1)'(held_reg);
    assign frac        = $signed({1'b0, phase_reg[PHASE_FRAC_BITS-1:0]});
    assign rounded     = prod_reg + HALF;
    assign delta       = rounded[MW-1:PHASE_FRAC_BITS];
    assign interp_wide = (SAMPLE_BITS+2)'(held_reg) + delta;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        bypass_next     = bypass_reg;
        rate_step_next  = rate_step_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        held_next       = held_reg;
        have_held_next  = have_held_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        pass_next       = pass_reg;
        prod_next       = prod_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        produce         = 1'b0;
        produce_value   = '0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        // Register writes are for the user to make only while idle; the block itself does not enforce it.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BYPASS:    bypass_next    = cfg_wdata[0];
                CFG_RATE_STEP: rate_step_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cur_next  = s_in_sample;
                    last_next = s_in_last;
                    pass_next = bypass_reg;
                    step_next = step_sat;
                    if (bypass_reg) begin
                        pend_next       = s_in_sample;
                        pend_valid_next = 1'b1;
                        state_next      = S_FLUSH;
                    end else if (have_held_reg) begin
                        state_next = S_INTERP;
                    end else begin
                        // First sample of a clip is only held.
                        held_next      = s_in_sample;
                        have_held_next = 1'b1;
                        state_next     = s_in_last ? S_TAIL : S_FLUSH;
                    end
                end
            end
            S_INTERP: begin
                if (phase_reg < ONE) begin
                    prod_next  = MW'(diff * frac);
                    phase_next = phase_reg + step_reg;
                    state_next = S_ROUND;
                end else begin
                    phase_next     = phase_reg - ONE;
                    held_next      = cur_reg;
                    have_held_next = 1'b1;
                    state_next     = last_reg ? S_TAIL : S_FLUSH;
                end
            end
            S_ROUND: begin
                if (can_produce) begin
                    produce       = 1'b1;
                    produce_value = interp_wide[SAMPLE_BITS-1:0];
                    state_next    = S_INTERP;
                end
            end
            S_TAIL: begin
                // Copies of the last sample, then a zero when landing exactly on the end.
                if (phase_reg < ONE) begin
                    if (can_produce) begin
                        produce       = 1'b1;
                        produce_value = cur_reg;
                        phase_next    = phase_reg + step_reg;
                    end
                end else if (phase_reg == ONE) begin
                    if (can_produce) begin
                        produce       = 1'b1;
                        produce_value = '0;
                        state_next    = S_FLUSH;
                    end
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_sample_next = pend_reg;
                        out_last_next   = last_reg;
                        pend_valid_next = 1'b0;
                    end
                    // End of a non-bypassed clip returns the interpolation state to zero.
                    if (last_reg && !pass_reg) begin
                        held_next      = '0;
                        phase_next     = '0;
                        have_held_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // A new result pushes the previous one out; the newest waits for its last mark.
        if (produce) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_sample_next = pend_reg;
                out_last_next   = 1'b0;
            end
            pend_next       = produce_value;
            pend_valid_next = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            bypass_reg     <= 1'b0;
            rate_step_reg  <= ONE;
            phase_reg      <= '0;
            held_reg       <= '0;
            have_held_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            bypass_reg     <= bypass_next;
            rate_step_reg  <= rate_step_next;
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            have_held_reg  <= have_held_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        step_reg       <= step_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        pass_reg       <= pass_next;
        prod_reg       <= prod_next;
        pend_reg       <= pend_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    // Nothing is left waiting in the one-deep hold when a new beat may enter.
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("result still pending while ready for input");

    // Without a held sample the phase and held sample are at rest.
    a_rest_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_held_reg |-> (phase_reg == '0 && held_reg == '0))
        else $error("phase or held sample not cleared between clips");

    // Interpolation runs only against a held sample.
    a_interp_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INTERP || state_reg == S_ROUND) |-> have_held_reg)
        else $error("interpolation without a held sample");

    // The phase always stays below one plus the largest step.
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < PHASE_BOUND)
        else $error("phase out of range");

    // A taken beat with nothing new behind it leaves the output empty.
    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !produce && !(state_reg == S_FLUSH && pend_valid_reg))
        |=> !m_valid)
        else $error("output beat repeated");

endmodule
